// ----- rtl/msp_pkg.sv -----
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the matrix saddle point finder.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int DATA_W = 32;   // element width
    localparam int POS_W  = 3;    // reported row / column width
    localparam int CFG_W  = 4;    // size register width
    localparam int CIDX_W = 1;    // register index width

    // register indexes on the configuration port
    localparam logic [CIDX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_COL_COUNT = 1'd1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FLUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // write accepted element, update row min / column max
        logic scan_adv;  // step scan position
        logic take;      // capture current match into hold register
        logic flush;     // emit the closing result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic at_end;      // position is the last element of the matrix
        logic match;       // current read entry is a saddle point
        logic hold_valid;  // a found result is held back
        logic out_free;    // output register can take a word this cycle
    } dp_stat_t;

endpackage

// ----- rtl/msp_if.sv -----
// ----------------------------------------------------------------------------
// msp_if
// Valid/ready channels: element input and saddle point result.
// ----------------------------------------------------------------------------
interface msp_in_if;
    logic                       valid;
    logic                       ready;
    logic [msp_pkg::DATA_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface msp_out_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [msp_pkg::DATA_W-1:0] point_value;
    logic [msp_pkg::POS_W-1:0]  point_row;
    logic [msp_pkg::POS_W-1:0]  point_col;
    logic                       last_result;

    modport source (output valid, output found, output point_value, output point_row,
                    output point_col, output last_result, input ready);
    modport sink   (input valid, input found, input point_value, input point_row,
                    input point_col, input last_result, output ready);
endinterface

// ----- rtl/msp_ram.sv -----
// ----------------------------------------------------------------------------
// msp_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/msp_ctrl.sv -----
// ----------------------------------------------------------------------------
// msp_ctrl
// Sequencer: load phase, entry-by-entry scan, closing result.
// ----------------------------------------------------------------------------
module msp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              elem_valid,
    output logic              elem_ready,
    input  msp_pkg::dp_stat_t stat,
    output msp_pkg::dp_cmd_t  cmd
);

    msp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msp_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        elem_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            msp_pkg::ST_LOAD:
            begin
                elem_ready = 1'b1;
                if (elem_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.at_end)
                    begin
                        state_next = msp_pkg::ST_SCAN_RD;
                    end
                end
            end
            msp_pkg::ST_SCAN_RD:
            begin
                // RAM read data lands next cycle
                state_next = msp_pkg::ST_SCAN_CMP;
            end
            msp_pkg::ST_SCAN_CMP:
            begin
                // a new match displaces the held one; wait if output is busy
                if (!(stat.match && stat.hold_valid && !stat.out_free))
                begin
                    cmd.take     = stat.match;
                    cmd.scan_adv = 1'b1;
                    state_next   = stat.at_end ? msp_pkg::ST_FLUSH : msp_pkg::ST_SCAN_RD;
                end
            end
            msp_pkg::ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = msp_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = msp_pkg::ST_LOAD;
            end
        endcase
    end

    a_flush_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> stat.out_free)
        else $error("closing word pushed into a busy output register");

    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && stat.hold_valid) |-> stat.out_free)
        else $error("held word dropped on a busy output register");

    a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == msp_pkg::ST_LOAD && !cmd.scan_adv))
        else $error("element load outside the load phase");

    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msp_pkg::ST_FLUSH && stat.out_free) |=> state_reg == msp_pkg::ST_LOAD)
        else $error("flush did not return to load");

endmodule

// ----- rtl/msp_dp.sv -----
// ----------------------------------------------------------------------------
// msp_dp
// Datapath: size registers, element RAM, row minimum / column maximum,
// position counters, held result and output register.
// ----------------------------------------------------------------------------
module msp_dp #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [msp_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [msp_pkg::CFG_W-1:0]    cfg_data,
    input  logic [msp_pkg::DATA_W-1:0]   element_value,
    input  msp_pkg::dp_cmd_t             cmd,
    output msp_pkg::dp_stat_t            stat,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         found,
    output logic [msp_pkg::DATA_W-1:0]   point_value,
    output logic [msp_pkg::POS_W-1:0]    point_row,
    output logic [msp_pkg::POS_W-1:0]    point_col,
    output logic                         last_result
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [msp_pkg::CFG_W-1:0] row_count_reg, col_count_reg;
    logic [RW-1:0]             rows_last;
    logic [CW-1:0]             cols_last;
    logic [RW-1:0]             pos_r_reg, pos_r_next;
    logic [CW-1:0]             pos_c_reg, pos_c_next;
    logic [AW-1:0]             addr;
    logic [msp_pkg::DATA_W-1:0] rd_data;

    logic signed [msp_pkg::DATA_W-1:0] row_min_reg [MAX_ROWS];
    logic signed [msp_pkg::DATA_W-1:0] col_max_reg [MAX_COLS];
    logic signed [msp_pkg::DATA_W-1:0] elem_s;

    logic                       hold_valid_reg, hold_valid_next;
    logic [msp_pkg::DATA_W-1:0] hold_value_reg;
    logic [RW-1:0]              hold_row_reg;
    logic [CW-1:0]              hold_col_reg;

    logic                       out_valid_reg, out_valid_next;
    logic                       push_mid;

    assign elem_s = $signed(element_value);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= msp_pkg::CFG_W'(8);
            col_count_reg <= msp_pkg::CFG_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msp_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_data;
                msp_pkg::CFG_COL_COUNT: col_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp sizes: zero counts as one, above max counts as max
    always_comb
    begin
        if (row_count_reg == '0)
            rows_last = '0;
        else if (row_count_reg > msp_pkg::CFG_W'(MAX_ROWS))
            rows_last = RW'(MAX_ROWS - 1);
        else
            rows_last = RW'(row_count_reg - 1'b1);

        if (col_count_reg == '0)
            cols_last = '0;
        else if (col_count_reg > msp_pkg::CFG_W'(MAX_COLS))
            cols_last = CW'(MAX_COLS - 1);
        else
            cols_last = CW'(col_count_reg - 1'b1);
    end

    assign stat.at_end = (pos_r_reg == rows_last) && (pos_c_reg == cols_last);

    // shared load / scan position
    always_comb
    begin
        pos_r_next = pos_r_reg;
        pos_c_next = pos_c_reg;
        if (cfg_we)
        begin
            pos_r_next = '0;
            pos_c_next = '0;
        end
        else if (cmd.load || cmd.scan_adv)
        begin
            if (pos_c_reg == cols_last)
            begin
                pos_c_next = '0;
                pos_r_next = (pos_r_reg == rows_last) ? '0 : pos_r_reg + 1'b1;
            end
            else
            begin
                pos_c_next = pos_c_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_r_reg <= '0;
            pos_c_reg <= '0;
        end
        else
        begin
            pos_r_reg <= pos_r_next;
            pos_c_reg <= pos_c_next;
        end
    end

    assign addr = AW'(AW'(pos_r_reg) * AW'(MAX_COLS)) + AW'(pos_c_reg);

    msp_ram #(
        .WIDTH (msp_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (addr),
        .wdata (element_value),
        .raddr (addr),
        .rdata (rd_data)
    );

    // running row minimum and column maximum, first of row/column seeds
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (pos_c_reg == '0 || elem_s < row_min_reg[pos_r_reg])
                row_min_reg[pos_r_reg] <= elem_s;
            if (pos_r_reg == '0 || elem_s > col_max_reg[pos_c_reg])
                col_max_reg[pos_c_reg] <= elem_s;
        end
    end

    assign stat.match = (rd_data == row_min_reg[pos_r_reg]) &&
                        (rd_data == col_max_reg[pos_c_reg]);

    // one found word is held back until we know whether it is the last
    assign push_mid        = cmd.take && hold_valid_reg;
    assign hold_valid_next = cmd.take ? 1'b1 : (cmd.flush ? 1'b0 : hold_valid_reg);
    assign stat.hold_valid = hold_valid_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        if (push_mid || cmd.flush)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            hold_value_reg <= rd_data;
            hold_row_reg   <= pos_r_reg;
            hold_col_reg   <= pos_c_reg;
        end
        if (push_mid)
        begin
            found       <= 1'b1;
            point_value <= hold_value_reg;
            point_row   <= msp_pkg::POS_W'(hold_row_reg);
            point_col   <= msp_pkg::POS_W'(hold_col_reg);
            last_result <= 1'b0;
        end
        else if (cmd.flush)
        begin
            // no held word means no saddle point: all-zero "none" word
            found       <= hold_valid_reg;
            point_value <= hold_valid_reg ? hold_value_reg : '0;
            point_row   <= hold_valid_reg ? msp_pkg::POS_W'(hold_row_reg) : '0;
            point_col   <= hold_valid_reg ? msp_pkg::POS_W'(hold_col_reg) : '0;
            last_result <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/matrix_saddle_point_finder_core.sv -----
// ----------------------------------------------------------------------------
// matrix_saddle_point_finder_core
// Loads a row-major signed matrix and reports every saddle point.
// ----------------------------------------------------------------------------
// Elements load at one word per cycle. After the last element the block
// scans the stored matrix row by row, each entry by a registered read of
// the element RAM and then the compare against the row minimum and column
// maximum; the scan waits while the result side stalls. The element
// input is held off from the last element until the closing word (last_result
// set) is in the output register. A matrix with no saddle point yields one
// word with found clear. Sizes are to be written only while idle; the block
// itself does not enforce this. Any write restarts the load at row 0, column 0.
module matrix_saddle_point_finder_core #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    msp_in_if.sink                      elem,
    msp_out_if.source                   result,
    input  logic                        cfg_we,
    input  logic [msp_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [msp_pkg::CFG_W-1:0]   cfg_data
);

    msp_pkg::dp_cmd_t  cmd;
    msp_pkg::dp_stat_t stat;

    msp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem.valid),
        .elem_ready (elem.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    msp_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_value (elem.element_value),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .found         (result.found),
        .point_value   (result.point_value),
        .point_row     (result.point_row),
        .point_col     (result.point_col),
        .last_result   (result.last_result)
    );

endmodule
